@@ hw/rtl/stft_pkg.sv @@
// Shared constants, types and functions for the STFT spectrogram block.
// No dependencies; used by controller, datapath and top level.
`default_nettype none
package stft_pkg;
  localparam int MAX_FFT = 64;
  localparam int LOG_MAX = 6;
  localparam int SAMPLE_BITS = 16;

  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [1:0] REG_OVERLAP_COUNT = 2'd1;
  localparam logic [1:0] REG_FFT_SIZE_LOG2 = 2'd2;

  localparam logic OP_LOAD_COEF = 1'b0;
  localparam logic OP_PUSH_SAMPLE = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_clr;   // clear work entry (zero pad)
    logic       load_en;    // windowed sample read issued
    logic       load_wr;    // write windowed sample into work
    logic [5:0] load_idx;
    logic [5:0] ring_addr;
    logic [5:0] win_addr;   // window coefficient, natural order
    logic       bf_rd;      // read butterfly operands
    logic       bf_mul;     // twiddle multiply stage
    logic       bf_wr;      // write butterfly results
    logic [5:0] bf_p;
    logic [5:0] bf_q;
    logic [4:0] bf_k;
    logic       out_rd;     // read bin for output
    logic [5:0] out_idx;
  } stft_cmd_t;

  // Quarter-wave cosine table, Q1.15 with +1.0 as 32768
  function automatic logic [16:0] quarter_cos(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0: v = 17'd32768;  5'd1: v = 17'd32610;  5'd2: v = 17'd32138;
      5'd3: v = 17'd31357;  5'd4: v = 17'd30274;  5'd5: v = 17'd28899;
      5'd6: v = 17'd27246;  5'd7: v = 17'd25330;  5'd8: v = 17'd23170;
      5'd9: v = 17'd20788;  5'd10: v = 17'd18205; 5'd11: v = 17'd15447;
      5'd12: v = 17'd12540; 5'd13: v = 17'd9512;  5'd14: v = 17'd6393;
      5'd15: v = 17'd3212;  default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [17:0] tw_cos(input logic [4:0] k);
    logic signed [17:0] v;
    if (k <= 5'd16) v = signed'({1'b0, quarter_cos(k)});
    else v = -signed'({1'b0, quarter_cos(5'(6'd32 - {1'b0, k}))});
    return v;
  endfunction

  function automatic logic signed [17:0] tw_sin(input logic [4:0] k);
    logic signed [17:0] v;
    if (k <= 5'd16) v = signed'({1'b0, quarter_cos(5'(5'd16 - k))});
    else v = signed'({1'b0, quarter_cos(5'(k - 5'd16))});
    return v;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) r = 24'sh7FFFFF;
    else if (v < -48'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // round half up of v / 2^15
  function automatic logic signed [47:0] rnd15(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd16384;
    return t >>> 15;
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/stft_ctrl.sv @@
// Sequencer for the STFT block: windowing, FFT stages, bin output.
// Depends on stft_pkg.
`default_nettype none
module stft_ctrl
  import stft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [6:0]  len,
  input  wire logic [2:0]  nlog,
  input  wire logic [5:0]  seg_base,
  input  wire logic        out_ready,
  output stft_cmd_t        cmd,
  output logic             busy,
  output logic             out_load,
  output logic             out_last,
  output logic [5:0]       out_bin
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_BF   = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;
  localparam logic [2:0] ST_OWAIT = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  logic [2:0] state;
  logic [6:0] cnt;        // load index / output bin
  logic [2:0] stage;      // butterfly stage s, h = 2^s
  logic [4:0] bfly;       // butterfly within stage
  logic [1:0] phase;      // read, multiply, write

  logic [6:0] n_val;
  logic [5:0] h_val;
  logic [5:0] j_val;
  logic [5:0] grp;
  logic [5:0] p_idx;
  logic [5:0] rev;
  logic [5:0] half;

  assign n_val = 7'd1 << nlog;
  assign half  = n_val[6:1];
  assign h_val = 6'd1 << stage;
  assign j_val = {1'b0, bfly} & (h_val - 6'd1);
  assign grp   = ({1'b0, bfly} >> stage) << (stage + 3'd1);
  assign p_idx = grp | j_val;

  // bit reverse load index over nlog bits
  always_comb begin
    rev = '0;
    for (int b = 0; b < LOG_MAX; b++) begin
      if (3'(b) < nlog) rev[3'(nlog - 3'd1 - 3'(b))] = cnt[b];
    end
  end

  always_comb begin
    cmd = '0;
    cmd.load_idx  = rev;
    cmd.ring_addr = seg_base + cnt[5:0];
    cmd.win_addr  = cnt[5:0];
    cmd.load_en   = (state == ST_LOAD) && (cnt < len);
    cmd.load_clr  = (state == ST_LOAD) && !(cnt < len);
    cmd.bf_p  = p_idx;
    cmd.bf_q  = p_idx + h_val;
    cmd.bf_k  = 5'(j_val << (3'd5 - stage));
    cmd.bf_rd  = (state == ST_BF) && (phase == 2'd0);
    cmd.bf_mul = (state == ST_BF) && (phase == 2'd1);
    cmd.bf_wr  = (state == ST_BF) && (phase == 2'd2);
    cmd.out_rd  = (state == ST_OUT);
    cmd.out_idx = cnt[5:0];
    cmd.load_wr = (state == ST_DRAIN) || ((state == ST_LOAD) && cnt != 7'd0);
  end

  assign busy     = (state != ST_IDLE);
  assign out_load = (state == ST_OWAIT);
  assign out_last = (cnt[5:0] == half);
  assign out_bin  = cnt[5:0];

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      stage <= '0;
      bfly <= '0;
      phase <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_LOAD;
            cnt <= '0;
          end
        end
        ST_LOAD: begin
          // one entry per cycle; its windowed data is written to the work memory in the next cycle
          if (cnt == n_val - 7'd1) begin
            state <= ST_DRAIN;
          end
          cnt <= cnt + 7'd1;
        end
        ST_DRAIN: begin
          stage <= '0;
          bfly <= '0;
          phase <= '0;
          if (nlog == 3'd0) begin
            state <= ST_OUT;
            cnt <= '0;
          end else state <= ST_BF;
        end
        ST_BF: begin
          if (phase == 2'd2) begin
            phase <= '0;
            if ({1'b0, bfly} == half - 6'd1) begin
              bfly <= '0;
              if (stage == nlog - 3'd1) begin
                state <= ST_OUT;
                cnt <= '0;
              end else stage <= stage + 3'd1;
            end else bfly <= bfly + 5'd1;
          end else phase <= phase + 2'd1;
        end
        ST_OUT: state <= ST_OWAIT;
        ST_OWAIT: begin
          if (out_ready) begin
            if (cnt[5:0] == half) state <= ST_IDLE;
            else begin
              cnt <= cnt + 7'd1;
              state <= ST_OUT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/stft_dp.sv @@
// Datapath for the STFT block: window and ring memories, work memory,
// windowing multiplier and butterfly unit. Depends on stft_pkg.
`default_nettype none
module stft_dp
  import stft_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               coef_we,
  input  wire logic [5:0]         coef_addr,
  input  wire logic signed [15:0] coef_data,
  input  wire logic               ring_we,
  input  wire logic [5:0]         ring_waddr,
  input  wire logic signed [15:0] ring_data,
  input  stft_cmd_t               cmd,
  output logic signed [23:0]      bin_re,
  output logic signed [23:0]      bin_im
);
  logic signed [15:0] win_mem [MAX_FFT];
  logic signed [15:0] ring_mem [MAX_FFT];
  logic signed [23:0] work_re [MAX_FFT];
  logic signed [23:0] work_im [MAX_FFT];

  logic signed [15:0] win_q, ring_q;
  logic               ld_v, ld_clr;
  logic [5:0]         ld_idx;

  logic signed [23:0] ar, ai, br, bi;
  logic signed [47:0] tr, ti;
  logic [5:0]         p_r, q_r;

  logic signed [47:0] prod;
  logic signed [23:0] wval;
  logic signed [23:0] a_p, a_q, b_p, b_q;

  // Coefficient and sample stores
  always_ff @(posedge clk) begin
    if (coef_we) win_mem[coef_addr] <= coef_data;
    if (ring_we) ring_mem[ring_waddr] <= ring_data;
    win_q  <= win_mem[cmd.win_addr];
    ring_q <= ring_mem[cmd.ring_addr];
  end

  // Windowing: product of sample and coefficient, stage registered
  assign prod = 48'(ring_q) * 48'(win_q);
  assign wval = ld_clr ? 24'sd0 : sat24(rnd15(prod));

  // Butterfly: twiddle product then add/sub, saturated
  assign a_p = sat24(48'(ar) + rnd15(tr));
  assign b_p = sat24(48'(ai) + rnd15(ti));
  assign a_q = sat24(48'(ar) - rnd15(tr));
  assign b_q = sat24(48'(ai) - rnd15(ti));

  always_ff @(posedge clk) begin
    if (cmd.load_en || cmd.load_clr) begin
      ld_idx <= cmd.load_idx;
      ld_clr <= cmd.load_clr;
    end
    ld_v <= cmd.load_en || cmd.load_clr;
    if (cmd.load_wr && ld_v) begin
      work_re[ld_idx] <= wval;
      work_im[ld_idx] <= 24'sd0;
    end
    if (cmd.bf_rd) begin
      ar <= work_re[cmd.bf_p];
      ai <= work_im[cmd.bf_p];
      br <= work_re[cmd.bf_q];
      bi <= work_im[cmd.bf_q];
      p_r <= cmd.bf_p;
      q_r <= cmd.bf_q;
    end
    if (cmd.bf_mul) begin
      tr <= 48'(br) * 48'(tw_cos(cmd.bf_k)) + 48'(bi) * 48'(tw_sin(cmd.bf_k));
      ti <= 48'(bi) * 48'(tw_cos(cmd.bf_k)) - 48'(br) * 48'(tw_sin(cmd.bf_k));
    end
    if (cmd.bf_wr) begin
      work_re[p_r] <= a_p;
      work_im[p_r] <= b_p;
      work_re[q_r] <= a_q;
      work_im[q_r] <= b_q;
    end
    if (cmd.out_rd) begin
      bin_re <= work_re[cmd.out_idx];
      bin_im <= work_im[cmd.out_idx];
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/stft_spectrogram_top.sv @@
// STFT spectrogram top level: stream ports, config, segment bookkeeping.
// Depends on stft_pkg, stft_ctrl, stft_dp.
// A sample that completes a segment starts the windowed load, the FFT stages and the
// bin output; s_axis_tready stays low until the last bin has been accepted, so one
// segment is processed at a time. Other items are taken without holding the input.
// Reset (rst, synchronous): registers to 64/0/0, counters to zero, no clear pass.
`default_nettype none
module stft_spectrogram_top
  import stft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // coef_index[5:0], coef[21:6], sample[37:22]
  input  wire logic        s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,  // bin_index, bin_real, bin_imag, segment_center
  output logic             m_axis_tlast   // last_bin
);
  logic [6:0]  window_length;
  logic [5:0]  overlap_count;
  logic [2:0]  fft_size_log2;
  logic [31:0] sample_total, segment_start, center;
  logic [6:0]  len, ovl, hop;
  logic [2:0]  plog, nlog;
  logic [31:0] diff, tot_next, seg_next;
  logic        busy, start, out_load, out_last, beat, is_push;
  logic [5:0]  seg_base, out_bin;
  logic signed [23:0] bin_re, bin_im;
  stft_cmd_t   cmd;

  assign beat = s_axis_tvalid && s_axis_tready;
  assign is_push = (s_axis_tuser == OP_PUSH_SAMPLE);
  assign s_axis_tready = !busy && !m_axis_tvalid;

  // Effective geometry
  always_comb begin
    len = (window_length == 7'd0) ? 7'd1 : (window_length > 7'd64) ? 7'd64 : window_length;
    ovl = (overlap_count == 6'd0) ? {1'b0, len[6:1]} : {1'b0, overlap_count};
    if (ovl >= len) ovl = len - 7'd1;
    hop = len - ovl;
    plog = 3'd6;
    for (int b = 5; b >= 0; b--) if ((7'd1 << b) >= len) plog = 3'(b);
    nlog = (fft_size_log2 == 3'd0 || fft_size_log2 < plog) ? plog :
           (fft_size_log2 > 3'd6) ? 3'd6 : fft_size_log2;
  end

  assign tot_next = sample_total + 32'd1;
  assign diff = tot_next - segment_start;
  assign seg_next = (diff > {25'd0, len}) ? tot_next - {25'd0, len} : segment_start;
  assign start = beat && is_push && (diff >= {25'd0, len});

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= 7'd64;
      overlap_count <= '0;
      fft_size_log2 <= '0;
      sample_total <= '0;
      segment_start <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: window_length <= cfg_data;
          REG_OVERLAP_COUNT: overlap_count <= cfg_data[5:0];
          REG_FFT_SIZE_LOG2: fft_size_log2 <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (beat && is_push) sample_total <= tot_next;
      if (start) begin
        seg_base <= seg_next[5:0];
        center <= seg_next + {26'd0, len[6:1]};
        segment_start <= seg_next + {25'd0, hop};
      end
      if (out_load && !m_axis_tvalid) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && !m_axis_tvalid) begin
      m_axis_tdata <= {2'd0, center, bin_im, bin_re, out_bin};
      m_axis_tlast <= out_last;
    end
  end

  stft_ctrl u_ctrl (
    .clk, .rst, .start, .len, .nlog, .seg_base,
    .out_ready(!m_axis_tvalid), .cmd, .busy, .out_load, .out_last, .out_bin
  );

  stft_dp u_dp (
    .clk,
    .coef_we(beat && !is_push), .coef_addr(s_axis_tdata[5:0]),
    .coef_data(s_axis_tdata[21:6]),
    .ring_we(beat && is_push), .ring_waddr(sample_total[5:0]),
    .ring_data(s_axis_tdata[37:22]),
    .cmd, .bin_re, .bin_im
  );
endmodule
`default_nettype wire

@@ tb/tb_stft_spectrogram_top.sv @@
// Testbench for stft_spectrogram_top: coefficient loads and sample beats in, spectrum bins out.
// Depends on stft_pkg and the RTL of stft_spectrogram_top; a scoreboard class predicts each bin.
module tb_stft_spectrogram_top;
  import stft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit [5:0]  idx;
    bit [23:0] re;
    bit [23:0] im;
    bit [31:0] center;
    bit        last;
  } spec_bin_t;

  // Fixed-point STFT predictor and queue of bins still owed by the block
  class spectrum_board;
    int unsigned win_len = 64, ovl_cnt = 0, fft_log2 = 0;
    longint coef_mem[MAX_FFT];
    longint ring[MAX_FFT];
    longint wr[MAX_FFT], wi[MAX_FFT];
    int unsigned total = 0, seg_start = 0;
    spec_bin_t bins_owed[$];
    int errors = 0;
    int qcos[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                     20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

    function void set_reg(logic [1:0] index, int unsigned value);
      if (index == REG_WINDOW_LENGTH) win_len = value & 'h7F;
      else if (index == REG_OVERLAP_COUNT) ovl_cnt = value & 'h3F;
      else if (index == REG_FFT_SIZE_LOG2) fft_log2 = value & 'h7;
    endfunction

    function longint clip24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function longint round15(longint v);
      return (v + 16384) >>> 15;
    endfunction

    function void transform(int unsigned n);
      int unsigned nbits, r, t, stride, k, p, q;
      longint tmp, c, s, br, bi, tr, ti, ar, ai;
      nbits = 0;
      while ((1 << nbits) < n) nbits++;
      // bit-reversed reorder
      for (int unsigned i = 0; i < n; i++) begin
        r = 0; t = i;
        for (int b = 0; b < nbits; b++) begin
          r = (r << 1) | (t & 1); t >>= 1;
        end
        if (r > i) begin
          tmp = wr[i]; wr[i] = wr[r]; wr[r] = tmp;
          tmp = wi[i]; wi[i] = wi[r]; wi[r] = tmp;
        end
      end
      // radix-2 stages, no scaling
      for (int unsigned h = 1; h < n; h <<= 1) begin
        stride = 64 / (2 * h);
        for (int unsigned i = 0; i < n; i += 2 * h)
          for (int unsigned j = 0; j < h; j++) begin
            k = (j * stride) % 64;
            c = (k <= 16) ? qcos[k] : -qcos[32 - k];
            s = (k <= 16) ? qcos[16 - k] : qcos[k - 16];
            p = i + j; q = i + j + h;
            br = wr[q]; bi = wi[q];
            tr = round15(br * c + bi * s);
            ti = round15(bi * c - br * s);
            ar = wr[p]; ai = wi[p];
            wr[p] = clip24(ar + tr); wi[p] = clip24(ai + ti);
            wr[q] = clip24(ar - tr); wi[q] = clip24(ai - ti);
          end
      end
    endfunction

    function void note_input(logic op, logic [5:0] cidx, logic [15:0] coef,
                             logic [15:0] smp);
      int unsigned len, ovl, hop, pw, n, diff, half;
      spec_bin_t sb;
      if (op == OP_LOAD_COEF) begin
        coef_mem[cidx] = longint'($signed(coef));
        return;
      end
      ring[total % MAX_FFT] = longint'($signed(smp));
      total++;
      len = win_len;
      if (len < 1) len = 1;
      if (len > MAX_FFT) len = MAX_FFT;
      ovl = (ovl_cnt == 0) ? len / 2 : ovl_cnt;
      if (ovl >= len) ovl = len - 1;
      hop = len - ovl;
      pw = 1;
      while (pw < len) pw <<= 1;
      n = pw;
      if (fft_log2 != 0) begin
        n = 1 << fft_log2;
        if (n < pw) n = pw;
        while (n > MAX_FFT) n >>= 1;
      end
      diff = total - seg_start;
      if (diff < len) return;
      if (diff > len) seg_start = total - len;
      for (int unsigned i = 0; i < n; i++) begin
        wr[i] = (i < len) ?
          clip24(round15(ring[(seg_start + i) % MAX_FFT] * coef_mem[i])) : 0;
        wi[i] = 0;
      end
      transform(n);
      half = n / 2;
      for (int unsigned i = 0; i <= half; i++) begin
        sb.idx = i; sb.re = wr[i][23:0]; sb.im = wi[i][23:0];
        sb.center = seg_start + len / 2; sb.last = (i == half);
        bins_owed.push_back(sb);
      end
      seg_start += hop;
    endfunction

    function void check_bin(logic [87:0] d, logic tl);
      spec_bin_t e;
      if (bins_owed.size() == 0) begin
        $error("unexpected bin beat: tdata %h", d);
        errors++;
        return;
      end
      e = bins_owed.pop_front();
      if (d[5:0] !== e.idx) begin
        $error("bin_index: expected %0d, actual %0d", e.idx, d[5:0]); errors++;
      end
      if (d[29:6] !== e.re) begin
        $error("bin_real: expected %h, actual %h", e.re, d[29:6]); errors++;
      end
      if (d[53:30] !== e.im) begin
        $error("bin_imag: expected %h, actual %h", e.im, d[53:30]); errors++;
      end
      if (d[85:54] !== e.center) begin
        $error("segment_center: expected %0d, actual %0d", e.center, d[85:54]); errors++;
      end
      if (tl !== e.last) begin
        $error("last_bin: expected %0d, actual %0d", e.last, tl); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tlast;

  spectrum_board board = new();
  int send_pct = 0, recv_pct = 0;
  bit hold_req = 0;

  stft_spectrogram_top DUT (.*);

  initial forever #10 clk = ~clk;

  initial begin
    #50_000_000;
    $display("stft_spectrogram_top: mismatch");
    $finish;
  end

  // Receiver: random stalls plus one long hold-off counted here
  int  hold_left = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) board.check_bin(m_axis_tdata, m_axis_tlast);
    if (hold_req && !hold_done) begin
      hold_left = 3000;
      hold_done = 1;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_pct);
  end

  task automatic write_reg(logic [1:0] index, logic [6:0] value);
    cfg_we <= 1; cfg_index <= index; cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(index, value);
  endtask

  task automatic send_beat(logic op, logic [5:0] cidx, logic [15:0] coef, logic [15:0] smp);
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {2'b00, smp, coef, cidx};
    do @(posedge clk); while (!s_axis_tready);
    board.note_input(op, cidx, coef, smp);
    if ($urandom_range(99) < send_pct) begin
      s_axis_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
  endtask

  task automatic drain(int settle);
    s_axis_tvalid <= 0;
    while (board.bins_owed.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic configure(int len, int ovl, int lg);
    write_reg(REG_WINDOW_LENGTH, len);
    write_reg(REG_OVERLAP_COUNT, ovl);
    write_reg(REG_FFT_SIZE_LOG2, lg);
  endtask

  task automatic random_run(int count);
    logic [15:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: send_beat(OP_LOAD_COEF, $urandom_range(63), $urandom, $urandom);
        1: send_beat(OP_PUSH_SAMPLE, $urandom, $urandom, $urandom_range(1) ? 16'h7FFF : 16'h8000);
        default: begin
          v = $urandom;
          send_beat(OP_PUSH_SAMPLE, $urandom, $urandom, v);
        end
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Sender sparse, receiver stalls often
    send_pct = 17; recv_pct = 59;

    // Fill the whole window store first so no coefficient is read unwritten
    for (int i = 0; i < MAX_FFT; i++)
      send_beat(OP_LOAD_COEF, i, (i == 0) ? 16'h7FFF : (i == 1) ? 16'h8000 :
                (i == 2) ? 16'h0000 : 16'($urandom), $urandom);
    drain(4);

    // Oversize length and FFT size, hop of one, long receiver hold-off
    configure(127, 63, 7);
    hold_req = 1;
    for (int i = 0; i < MAX_FFT; i++)
      send_beat(OP_PUSH_SAMPLE, $urandom, $urandom, $urandom);
    random_run(2);
    drain(700);

    // Receiver sparse, sender idles often; each change shortens the window
    send_pct = 59; recv_pct = 17;
    configure(33, 0, 5);
    random_run(4);
    drain(700);
    configure(16, 0, 0);
    random_run(4);
    drain(700);

    // No idling
    send_pct = 0; recv_pct = 0;
    configure(8, 7, 1);
    random_run(4);
    drain(700);

    // Directed: short window zero-padded to 8, sample extremes, saturation
    configure(4, 0, 3);
    send_beat(OP_PUSH_SAMPLE, 6'h3F, 16'hFFFF, 16'h7FFF);
    send_beat(OP_PUSH_SAMPLE, 6'h00, 16'h0000, 16'h8000);
    send_beat(OP_PUSH_SAMPLE, 6'h3F, 16'hFFFF, 16'h7FFF);
    send_beat(OP_PUSH_SAMPLE, 6'h00, 16'h0000, 16'h8000);
    send_beat(OP_LOAD_COEF, 6'd3, 16'h8000, 16'hFFFF);
    send_beat(OP_PUSH_SAMPLE, 6'h00, 16'h0000, 16'h0000);
    send_beat(OP_PUSH_SAMPLE, 6'h00, 16'h0000, 16'hFFFF);
    send_beat(OP_PUSH_SAMPLE, 6'h00, 16'h0000, 16'h0001);
    send_beat(OP_LOAD_COEF, 6'd3, 16'h7FFF, 16'h0000);
    send_beat(OP_PUSH_SAMPLE, 6'h00, 16'h0000, 16'h7FFF);
    send_beat(OP_PUSH_SAMPLE, 6'h00, 16'h0000, 16'h7FFF);
    drain(700);

    // Window length zero acts as one; overlap beyond it saturates
    configure(0, 5, 0);
    random_run(3);
    drain(700);

    if (board.errors == 0)
      $display("stft_spectrogram_top: match");
    else
      $display("stft_spectrogram_top: mismatch");
    $finish;
  end
endmodule
